// ===== hdl/dsa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsa_pkg
// Shared types, widths and codes of the Doppler search aiding block.
// ----------------------------------------------------------------------------
package dsa_pkg;

  // Field widths
  localparam int ModeW    = 3;
  localparam int ConsW    = 3;
  localparam int PrnW     = 6;
  localparam int KeyW     = ConsW + PrnW;
  localparam int DopW     = 25;
  localparam int CarW     = 31;
  localparam int FracW    = 40;
  localparam int SumW     = 56;
  localparam int CntW     = 16;
  localparam int BandW    = 16;
  localparam int CenterW  = 25;

  // Fractions are df/f scaled by 2^FracShift, Doppler is in 1/16 Hz
  localparam int FracShift  = 48;
  localparam int SubHzBits  = 4;
  localparam int ScaleShift = FracShift - SubHzBits;

  // Datapath widths
  localparam int DivNumW  = DopW + ScaleShift;
  localparam int QuoW     = SumW + 1;
  localparam int BrgW     = QuoW;
  localparam int CfW      = BrgW + 1;
  localparam int MulW     = CfW + CarW;
  localparam int DivSteps = DivNumW;
  localparam int MulSteps = CarW;
  localparam int StepW    = $clog2(DivSteps);

  // Stream and register port widths
  localparam int InDataW  = 112;
  localparam int OutDataW = 104;
  localparam int CfgAddrW = 6;
  localparam int CfgDataW = 64;
  localparam int RegIdxW  = 3;

  typedef enum logic [ModeW-1:0] {
    MODE_REP_COM  = 3'd0,
    MODE_REP_SAT  = 3'd1,
    MODE_SET_PRED = 3'd2,
    MODE_EST_COM  = 3'd3,
    MODE_EST_SAT  = 3'd4
  } mode_e;

  typedef enum logic [RegIdxW-1:0] {
    REG_BAND_WIDE   = 3'd0,
    REG_BAND_NARROW = 3'd1,
    REG_BAND_VNAR   = 3'd2,
    REG_BAND_ALM    = 3'd3,
    REG_CLK_FRAC    = 3'd4,
    REG_CLK_VALID   = 3'd5
  } reg_e;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_DSTART, ST_DIV, ST_FEND, ST_ACC, ST_WRM, ST_WRP,
    ST_MRD, ST_PICK, ST_BSTART, ST_BDIV, ST_BEND, ST_MSTART, ST_MUL, ST_OUT
  } state_e;

  typedef struct packed {
    logic [BandW-1:0] band_wide;
    logic [BandW-1:0] band_narrow;
    logic [BandW-1:0] band_vnar;
    logic [BandW-1:0] band_alm;
    logic [FracW-1:0] clk_frac;
    logic             clk_valid;
  } cfg_t;

  typedef struct packed {
    logic cap;
    logic div_frac;
    logic div_brg;
    logic div_step;
    logic frac_end;
    logic acc_upd;
    logic wr_meas;
    logic wr_pred;
    logic mem_clr;
    logic mem_rd;
    logic pick;
    logic brg_end;
    logic mul_start;
    logic mul_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    mode_e in_mode;
    mode_e mode;
    logic  need_brg;
  } sts_t;

endpackage

// ===== hdl/dsa_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsa_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module dsa_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/dsa_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsa_ctrl
// Sequencer: clearing pass, divider and multiplier step counts, handshakes.
// ----------------------------------------------------------------------------
module dsa_ctrl #(
  parameter int SatSlots = 512,
  parameter int SlotW    = 9
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_valid_i,
  input  logic               m_ready_i,
  input  dsa_pkg::sts_t      sts_i,
  output dsa_pkg::cmd_t      cmd_o,
  output logic [SlotW-1:0]   clr_addr_o,
  output logic               s_ready_o,
  output logic               m_valid_o
);

  dsa_pkg::state_e             state_q, state_d;
  logic [dsa_pkg::StepW-1:0]   step_q, step_d;
  logic [SlotW-1:0]            clr_q, clr_d;
  logic                        out_vld_q, out_vld_d;
  logic                        div_last, mul_last;

  assign div_last = (step_q == dsa_pkg::StepW'(dsa_pkg::DivSteps - 1));
  assign mul_last = (step_q == dsa_pkg::StepW'(dsa_pkg::MulSteps - 1));

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      dsa_pkg::ST_CLEAR: begin
        if (clr_q == SlotW'(SatSlots - 1)) state_d = dsa_pkg::ST_IDLE;
      end
      dsa_pkg::ST_IDLE: begin
        if (s_valid_i) begin
          case (sts_i.in_mode)
            dsa_pkg::MODE_REP_COM,
            dsa_pkg::MODE_REP_SAT:  state_d = dsa_pkg::ST_DSTART;
            dsa_pkg::MODE_SET_PRED: state_d = dsa_pkg::ST_WRP;
            dsa_pkg::MODE_EST_COM,
            dsa_pkg::MODE_EST_SAT:  state_d = dsa_pkg::ST_MRD;
            default:                state_d = dsa_pkg::ST_IDLE;
          endcase
        end
      end
      dsa_pkg::ST_DSTART: state_d = dsa_pkg::ST_DIV;
      dsa_pkg::ST_DIV: begin
        if (div_last) state_d = dsa_pkg::ST_FEND;
      end
      dsa_pkg::ST_FEND: begin
        state_d = (sts_i.mode == dsa_pkg::MODE_REP_COM) ? dsa_pkg::ST_ACC : dsa_pkg::ST_WRM;
      end
      dsa_pkg::ST_ACC:    state_d = dsa_pkg::ST_IDLE;
      dsa_pkg::ST_WRM:    state_d = dsa_pkg::ST_IDLE;
      dsa_pkg::ST_WRP:    state_d = dsa_pkg::ST_IDLE;
      dsa_pkg::ST_MRD:    state_d = dsa_pkg::ST_PICK;
      dsa_pkg::ST_PICK: begin
        state_d = sts_i.need_brg ? dsa_pkg::ST_BSTART : dsa_pkg::ST_MSTART;
      end
      dsa_pkg::ST_BSTART: state_d = dsa_pkg::ST_BDIV;
      dsa_pkg::ST_BDIV: begin
        if (div_last) state_d = dsa_pkg::ST_BEND;
      end
      dsa_pkg::ST_BEND:   state_d = dsa_pkg::ST_MSTART;
      dsa_pkg::ST_MSTART: state_d = dsa_pkg::ST_MUL;
      dsa_pkg::ST_MUL: begin
        if (mul_last) state_d = dsa_pkg::ST_OUT;
      end
      dsa_pkg::ST_OUT: begin
        if (!out_vld_q || m_ready_i) state_d = dsa_pkg::ST_IDLE;
      end
      default: state_d = dsa_pkg::ST_IDLE;
    endcase
  end

  // Commands and handshakes
  always_comb begin
    cmd_o     = '0;
    s_ready_o = 1'b0;
    case (state_q)
      dsa_pkg::ST_CLEAR:  cmd_o.mem_clr = 1'b1;
      dsa_pkg::ST_IDLE: begin
        s_ready_o = 1'b1;
        cmd_o.cap = s_valid_i;
      end
      dsa_pkg::ST_DSTART: cmd_o.div_frac  = 1'b1;
      dsa_pkg::ST_DIV:    cmd_o.div_step  = 1'b1;
      dsa_pkg::ST_FEND:   cmd_o.frac_end  = 1'b1;
      dsa_pkg::ST_ACC:    cmd_o.acc_upd   = 1'b1;
      dsa_pkg::ST_WRM:    cmd_o.wr_meas   = 1'b1;
      dsa_pkg::ST_WRP:    cmd_o.wr_pred   = 1'b1;
      dsa_pkg::ST_MRD:    cmd_o.mem_rd    = 1'b1;
      dsa_pkg::ST_PICK:   cmd_o.pick      = 1'b1;
      dsa_pkg::ST_BSTART: cmd_o.div_brg   = 1'b1;
      dsa_pkg::ST_BDIV:   cmd_o.div_step  = 1'b1;
      dsa_pkg::ST_BEND:   cmd_o.brg_end   = 1'b1;
      dsa_pkg::ST_MSTART: cmd_o.mul_start = 1'b1;
      dsa_pkg::ST_MUL:    cmd_o.mul_step  = 1'b1;
      dsa_pkg::ST_OUT:    cmd_o.out_load  = !out_vld_q || m_ready_i;
      default: ;
    endcase
  end

  // Step and clear counters, output valid
  always_comb begin
    step_d = step_q;
    if (cmd_o.div_frac || cmd_o.div_brg || cmd_o.mul_start) begin
      step_d = '0;
    end else if (cmd_o.div_step || cmd_o.mul_step) begin
      step_d = step_q + dsa_pkg::StepW'(1);
    end
    clr_d = cmd_o.mem_clr ? clr_q + SlotW'(1) : clr_q;
    out_vld_d = out_vld_q;
    if (cmd_o.out_load) begin
      out_vld_d = 1'b1;
    end else if (m_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= dsa_pkg::ST_CLEAR;
      step_q    <= '0;
      clr_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      step_q    <= step_d;
      clr_q     <= clr_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign clr_addr_o = clr_q;
  assign m_valid_o  = out_vld_q;

endmodule

// ===== hdl/dsa_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsa_dp
// Datapath: item capture, bit-serial divider, shift-add multiplier,
// running sum and count, per-satellite tables and result registers.
// ----------------------------------------------------------------------------
module dsa_dp #(
  parameter int SatSlots = 512,
  parameter int SlotW    = 9
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  dsa_pkg::cfg_t                     cfg_i,
  input  dsa_pkg::cmd_t                     cmd_i,
  input  logic [SlotW-1:0]                  clr_addr_i,
  input  logic [dsa_pkg::ModeW-1:0]         in_mode_i,
  input  logic [dsa_pkg::ConsW-1:0]         in_cons_i,
  input  logic [dsa_pkg::PrnW-1:0]          in_prn_i,
  input  logic [dsa_pkg::DopW-1:0]          in_dop_i,
  input  logic [dsa_pkg::CarW-1:0]          in_car_i,
  input  logic                              in_above_i,
  input  logic [dsa_pkg::FracW-1:0]         in_los_i,
  output dsa_pkg::sts_t                     sts_o,
  output logic [dsa_pkg::CenterW-1:0]       center_o,
  output logic [dsa_pkg::BandW-1:0]         half_o,
  output logic [dsa_pkg::CntW-1:0]          sats_o,
  output logic                              pinned_o,
  output logic                              search_o,
  output logic                              found_o,
  output logic [dsa_pkg::FracW-1:0]         mfrac_o
);

  localparam int DopW   = dsa_pkg::DopW;
  localparam int CarW   = dsa_pkg::CarW;
  localparam int FracW  = dsa_pkg::FracW;
  localparam int SumW   = dsa_pkg::SumW;
  localparam int CntW   = dsa_pkg::CntW;
  localparam int QW     = dsa_pkg::QuoW;
  localparam int BrgW   = dsa_pkg::BrgW;
  localparam int CfW    = dsa_pkg::CfW;
  localparam int MulW   = dsa_pkg::MulW;
  localparam int NumW   = dsa_pkg::DivNumW;
  localparam int KeyW   = dsa_pkg::KeyW;
  localparam int CenW   = dsa_pkg::CenterW;
  localparam int Shift  = dsa_pkg::ScaleShift;
  localparam int ResW   = MulW + 1 - Shift;
  localparam int MeasW  = FracW + 1;
  localparam int PredW  = FracW + 2;

  localparam logic [QW:0]     FLimP = (QW + 1)'((64'd1 << (FracW - 1)) - 64'd1);
  localparam logic [QW:0]     FLimN = (QW + 1)'(64'd1 << (FracW - 1));
  localparam logic [ResW-1:0] CLimP = ResW'((64'd1 << (CenW - 1)) - 64'd1);
  localparam logic [ResW-1:0] CLimN = ResW'(64'd1 << (CenW - 1));
  localparam logic [MulW:0]   RBias = (MulW + 1)'(1) << (Shift - 1);
  localparam logic [SumW-1:0] SumMax = {1'b0, {(SumW - 1){1'b1}}};
  localparam logic [SumW-1:0] SumMin = {1'b1, {(SumW - 1){1'b0}}};

  // Captured item
  dsa_pkg::mode_e      mode_q;
  logic [SlotW-1:0]    slot_q, slot_d;
  logic [DopW-1:0]     dop_q;
  logic [CarW-1:0]     car_q;
  logic                above_q;
  logic [FracW-1:0]    los_q;

  // Divider
  logic [NumW-1:0]     dnum_q, dnum_d;
  logic [CarW-1:0]     rem_q, rem_d;
  logic [CarW-1:0]     dvs_q, dvs_d;
  logic [QW-1:0]       quo_q, quo_d;
  logic                qovf_q, qovf_d;
  logic [CarW:0]       rs;
  logic                ge;

  // Accumulator and intermediate results
  logic [SumW-1:0]     sum_q, sum_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [FracW-1:0]    frac_q, frac_d;
  logic [BrgW-1:0]     brg_q, brg_d;

  // Table read captures
  logic                mv_q, pv_q, pabove_q;
  logic [FracW-1:0]    mfrac_q, plos_q;

  // Multiplier
  logic [CfW-1:0]      mmag_q;
  logic                mneg_q;
  logic [CarW-1:0]     mcar_q;
  logic [MulW-1:0]     prod_q, prod_d;

  // Result fields held from the multiplier start
  logic [dsa_pkg::BandW-1:0] half_q, half_d;
  logic                      srch_q, srch_d, fnd_q, fnd_d;
  logic [FracW-1:0]          mf_q, mf_d;

  // Output registers
  logic [CenW-1:0]           center_q, center_d;
  logic [dsa_pkg::BandW-1:0] half_out_q;
  logic [CntW-1:0]           sats_q;
  logic                      pin_q, srch_out_q, fnd_out_q;
  logic [FracW-1:0]          mf_out_q;

  // Misc combinational
  logic                dop_neg, sum_neg;
  logic [DopW-1:0]     dop_mag;
  logic [SumW-1:0]     sum_mag;
  logic                rnd;
  logic [QW:0]         qr, flim, fmag;
  logic [SumW:0]       sx;
  logic [QW-1:0]       bm;
  logic signed [CfW-1:0] cf;
  logic [CfW-1:0]      cf_mag;
  logic [MulW:0]       rb;
  logic [ResW-1:0]     res, clim, cm;
  logic [KeyW-1:0]     key;
  logic                est_sat;

  // RAM ports
  logic                meas_we, pred_we;
  logic [SlotW-1:0]    meas_wa, pred_wa;
  logic [MeasW-1:0]    meas_wd, meas_rd;
  logic [PredW-1:0]    pred_wd, pred_rd;

  // Reduce the satellite key to a table slot
  always_comb begin
    key = {in_cons_i, in_prn_i};
    for (int k = 2; k >= 0; k--) begin
      if (int'(key) >= (SatSlots << k)) key = key - KeyW'(SatSlots << k);
    end
    slot_d = SlotW'(key);
  end

  assign dop_neg = dop_q[DopW-1];
  assign dop_mag = dop_neg ? DopW'(~dop_q + DopW'(1)) : dop_q;
  assign sum_neg = sum_q[SumW-1];
  assign sum_mag = sum_neg ? SumW'(~sum_q + SumW'(1)) : sum_q;
  assign est_sat = (mode_q == dsa_pkg::MODE_EST_SAT);

  // Restoring divider, one quotient bit per step
  assign rs = {rem_q, dnum_q[NumW-1]};
  assign ge = (rs >= {1'b0, dvs_q});
  always_comb begin
    dnum_d = dnum_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    qovf_d = qovf_q;
    if (cmd_i.div_frac) begin
      dnum_d = {dop_mag, {Shift{1'b0}}};
      dvs_d  = car_q;
      rem_d  = '0;
      quo_d  = '0;
      qovf_d = 1'b0;
    end else if (cmd_i.div_brg) begin
      dnum_d = NumW'(sum_mag + SumW'(cnt_q >> 1));
      dvs_d  = CarW'(cnt_q);
      rem_d  = '0;
      quo_d  = '0;
      qovf_d = 1'b0;
    end else if (cmd_i.div_step) begin
      dnum_d = dnum_q << 1;
      rem_d  = ge ? CarW'(rs - {1'b0, dvs_q}) : CarW'(rs);
      quo_d  = {quo_q[QW-2:0], ge};
      qovf_d = qovf_q | quo_q[QW-1];
    end
  end

  // Round and saturate the report fraction
  always_comb begin
    rnd  = ({rem_q, 1'b0} >= {1'b0, dvs_q});
    qr   = {1'b0, quo_q} + (QW + 1)'(rnd);
    flim = dop_neg ? FLimN : FLimP;
    if (car_q == '0) begin
      fmag = (dop_mag != '0) ? flim : '0;
    end else if (qovf_q || (qr > flim)) begin
      fmag = flim;
    end else begin
      fmag = qr;
    end
    frac_d = cmd_i.frac_end ? (dop_neg ? FracW'(~fmag + (QW + 1)'(1)) : FracW'(fmag))
                            : frac_q;
  end

  // Saturating sum and count
  always_comb begin
    sx    = {sum_q[SumW-1], sum_q} + {{(SumW + 1 - FracW){frac_q[FracW-1]}}, frac_q};
    sum_d = sum_q;
    cnt_d = cnt_q;
    if (cmd_i.acc_upd) begin
      if (sx[SumW] != sx[SumW-1]) begin
        sum_d = sx[SumW] ? SumMin : SumMax;
      end else begin
        sum_d = sx[SumW-1:0];
      end
      if (cnt_q != '1) cnt_d = cnt_q + CntW'(1);
    end
  end

  // Bridge: rounded mean, halved again for a single report
  always_comb begin
    bm    = (cnt_q == CntW'(1)) ? QW'(({1'b0, quo_q} + (QW + 1)'(1)) >> 1) : quo_q;
    brg_d = brg_q;
    if (cmd_i.pick) begin
      brg_d = '0;
    end else if (cmd_i.brg_end) begin
      brg_d = sum_neg ? BrgW'(~bm + QW'(1)) : BrgW'(bm);
    end
  end

  // Pick the center fraction and the result fields
  always_comb begin
    cf     = '0;
    half_d = cfg_i.band_wide;
    srch_d = 1'b1;
    fnd_d  = est_sat && mv_q;
    mf_d   = (est_sat && mv_q) ? mfrac_q : '0;
    if (est_sat && mv_q) begin
      cf     = CfW'($signed(mfrac_q));
      half_d = cfg_i.band_alm;
    end else if (est_sat && pv_q) begin
      cf     = CfW'($signed(plos_q)) + (cfg_i.clk_valid ? CfW'($signed(cfg_i.clk_frac))
                                                        : CfW'($signed(brg_q)));
      half_d = cfg_i.band_alm;
      srch_d = pabove_q;
    end else if (cfg_i.clk_valid) begin
      cf     = CfW'($signed(cfg_i.clk_frac));
      half_d = cfg_i.band_vnar;
    end else if (cnt_q != '0) begin
      cf     = CfW'($signed(brg_q));
      half_d = (cnt_q >= CntW'(2)) ? cfg_i.band_narrow : cfg_i.band_wide;
    end
    cf_mag = cf[CfW-1] ? CfW'(~cf + CfW'(1)) : CfW'(cf);
  end

  // Shift-add multiply, carrier bits MSB first
  assign prod_d = cmd_i.mul_start ? '0 :
                  cmd_i.mul_step  ? MulW'((prod_q << 1) +
                                          (mcar_q[CarW-1] ? MulW'(mmag_q) : MulW'(0)))
                                  : prod_q;

  // Round, saturate and sign the center
  always_comb begin
    rb       = {1'b0, prod_q} + RBias;
    res      = rb[MulW:Shift];
    clim     = mneg_q ? CLimN : CLimP;
    cm       = (res > clim) ? clim : res;
    center_d = mneg_q ? CenW'(~cm + ResW'(1)) : CenW'(cm);
  end

  // Control-side state: sum and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      cnt_q <= '0;
    end else begin
      sum_q <= sum_d;
      cnt_q <= cnt_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      mode_q  <= dsa_pkg::mode_e'(in_mode_i);
      slot_q  <= slot_d;
      dop_q   <= in_dop_i;
      car_q   <= in_car_i;
      above_q <= in_above_i;
      los_q   <= in_los_i;
    end
    dnum_q <= dnum_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
    quo_q  <= quo_d;
    qovf_q <= qovf_d;
    frac_q <= frac_d;
    brg_q  <= brg_d;
    prod_q <= prod_d;
    if (cmd_i.pick) begin
      mv_q     <= meas_rd[FracW];
      mfrac_q  <= meas_rd[FracW-1:0];
      pv_q     <= pred_rd[FracW+1];
      pabove_q <= pred_rd[FracW];
      plos_q   <= pred_rd[FracW-1:0];
    end
    if (cmd_i.mul_start) begin
      mmag_q <= cf_mag;
      mneg_q <= cf[CfW-1];
      mcar_q <= car_q;
      half_q <= half_d;
      srch_q <= srch_d;
      fnd_q  <= fnd_d;
      mf_q   <= mf_d;
    end else if (cmd_i.mul_step) begin
      mcar_q <= mcar_q << 1;
    end
    if (cmd_i.out_load) begin
      center_q   <= center_d;
      half_out_q <= half_q;
      sats_q     <= cnt_q;
      pin_q      <= cfg_i.clk_valid;
      srch_out_q <= srch_q;
      fnd_out_q  <= fnd_q;
      mf_out_q   <= mf_q;
    end
  end

  // Tables: valid mark in the top bit, cleared by the sweep after reset
  assign meas_we = cmd_i.mem_clr | cmd_i.wr_meas;
  assign meas_wa = cmd_i.mem_clr ? clr_addr_i : slot_q;
  assign meas_wd = cmd_i.mem_clr ? '0 : {1'b1, frac_q};
  assign pred_we = cmd_i.mem_clr | cmd_i.wr_pred;
  assign pred_wa = cmd_i.mem_clr ? clr_addr_i : slot_q;
  assign pred_wd = cmd_i.mem_clr ? '0 : {1'b1, above_q, los_q};

  dsa_ram #(.Width(MeasW), .Depth(SatSlots)) u_meas_ram (
    .clk_i   (clk_i),
    .we_i    (meas_we),
    .waddr_i (meas_wa),
    .wdata_i (meas_wd),
    .re_i    (cmd_i.mem_rd),
    .raddr_i (slot_q),
    .rdata_o (meas_rd)
  );

  dsa_ram #(.Width(PredW), .Depth(SatSlots)) u_pred_ram (
    .clk_i   (clk_i),
    .we_i    (pred_we),
    .waddr_i (pred_wa),
    .wdata_i (pred_wd),
    .re_i    (cmd_i.mem_rd),
    .raddr_i (slot_q),
    .rdata_o (pred_rd)
  );

  // Status to the sequencer
  assign sts_o.in_mode  = dsa_pkg::mode_e'(in_mode_i);
  assign sts_o.mode     = mode_q;
  assign sts_o.need_brg = !cfg_i.clk_valid && (cnt_q != '0) && !(est_sat && meas_rd[FracW]);

  assign center_o = center_q;
  assign half_o   = half_out_q;
  assign sats_o   = sats_q;
  assign pinned_o = pin_q;
  assign search_o = srch_out_q;
  assign found_o  = fnd_out_q;
  assign mfrac_o  = mf_out_q;

endmodule

// ===== hdl/doppler_search_aiding_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// doppler_search_aiding_top
// GNSS acquisition aider: Doppler reports in, search windows out.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats on s_axis (tuser = mode) carry reports, predictions and
//   estimate requests. Estimates (modes 3 and 4) return one beat on m_axis
//   with center, half-width and status; other modes return nothing.
//   Registers are written over the APB port while the block is idle.
// Processing: a report (common or satellite) runs the 69-step serial
//   divider; a set prediction only writes its table entry. An estimate
//   runs 31 multiplier steps, after a divider pass for the mean fraction
//   when it needs a bridge term. One item is processed at a time.
// Reset: sum and count clear, then a sweep over every slot clears the
//   table valid marks; s_axis_tready stays low during the sweep.
// Stall: a finished result waits in the output register; new items are
//   still taken, and a following estimate holds until the result drains.
// ----------------------------------------------------------------------------
module doppler_search_aiding_top #(
  parameter int SAT_SLOTS = 512
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // fields from bit 0: constellation, prn, doppler, carrier,
  // above flag, line-of-sight fraction
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [dsa_pkg::InDataW-1:0]     s_axis_tdata,
  input  logic [dsa_pkg::ModeW-1:0]       s_axis_tuser,   // mode
  // fields from bit 0: center, half_width_hz, sats_used, clock_pinned,
  // searchable, measured_found, measured_fraction
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [dsa_pkg::OutDataW-1:0]    m_axis_tdata,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [dsa_pkg::CfgAddrW-1:0]    paddr,
  input  logic [dsa_pkg::CfgDataW-1:0]    pwdata,
  output logic [dsa_pkg::CfgDataW-1:0]    prdata,
  output logic                            pready
);

  localparam int SlotW = $clog2(SAT_SLOTS);

  dsa_pkg::cfg_t   cfg_q;
  dsa_pkg::cmd_t   cmd;
  dsa_pkg::sts_t   sts;
  dsa_pkg::reg_e   reg_idx;
  logic            cfg_wr;
  logic [SlotW-1:0] clr_addr;

  logic [dsa_pkg::CenterW-1:0] center;
  logic [dsa_pkg::BandW-1:0]   half;
  logic [dsa_pkg::CntW-1:0]    sats;
  logic                        pinned, search, found;
  logic [dsa_pkg::FracW-1:0]   mfrac;

  // Configuration registers
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign reg_idx = dsa_pkg::reg_e'(paddr[dsa_pkg::CfgAddrW-1:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.band_wide   <= 16'd5000;
      cfg_q.band_narrow <= 16'd1000;
      cfg_q.band_vnar   <= 16'd250;
      cfg_q.band_alm    <= 16'd250;
      cfg_q.clk_frac    <= '0;
      cfg_q.clk_valid   <= 1'b0;
    end else if (cfg_wr) begin
      case (reg_idx)
        dsa_pkg::REG_BAND_WIDE:   cfg_q.band_wide   <= pwdata[dsa_pkg::BandW-1:0];
        dsa_pkg::REG_BAND_NARROW: cfg_q.band_narrow <= pwdata[dsa_pkg::BandW-1:0];
        dsa_pkg::REG_BAND_VNAR:   cfg_q.band_vnar   <= pwdata[dsa_pkg::BandW-1:0];
        dsa_pkg::REG_BAND_ALM:    cfg_q.band_alm    <= pwdata[dsa_pkg::BandW-1:0];
        dsa_pkg::REG_CLK_FRAC:    cfg_q.clk_frac    <= pwdata[dsa_pkg::FracW-1:0];
        dsa_pkg::REG_CLK_VALID:   cfg_q.clk_valid   <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Register read back
  always_comb begin
    case (reg_idx)
      dsa_pkg::REG_BAND_WIDE:   prdata = dsa_pkg::CfgDataW'(cfg_q.band_wide);
      dsa_pkg::REG_BAND_NARROW: prdata = dsa_pkg::CfgDataW'(cfg_q.band_narrow);
      dsa_pkg::REG_BAND_VNAR:   prdata = dsa_pkg::CfgDataW'(cfg_q.band_vnar);
      dsa_pkg::REG_BAND_ALM:    prdata = dsa_pkg::CfgDataW'(cfg_q.band_alm);
      dsa_pkg::REG_CLK_FRAC:    prdata = dsa_pkg::CfgDataW'(cfg_q.clk_frac);
      dsa_pkg::REG_CLK_VALID:   prdata = dsa_pkg::CfgDataW'(cfg_q.clk_valid);
      default:                  prdata = '0;
    endcase
  end

  dsa_ctrl #(.SatSlots(SAT_SLOTS), .SlotW(SlotW)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_valid_i  (s_axis_tvalid),
    .m_ready_i  (m_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .clr_addr_o (clr_addr),
    .s_ready_o  (s_axis_tready),
    .m_valid_o  (m_axis_tvalid)
  );

  dsa_dp #(.SatSlots(SAT_SLOTS), .SlotW(SlotW)) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .cmd_i      (cmd),
    .clr_addr_i (clr_addr),
    .in_mode_i  (s_axis_tuser),
    .in_cons_i  (s_axis_tdata[2:0]),
    .in_prn_i   (s_axis_tdata[8:3]),
    .in_dop_i   (s_axis_tdata[33:9]),
    .in_car_i   (s_axis_tdata[64:34]),
    .in_above_i (s_axis_tdata[65]),
    .in_los_i   (s_axis_tdata[105:66]),
    .sts_o      (sts),
    .center_o   (center),
    .half_o     (half),
    .sats_o     (sats),
    .pinned_o   (pinned),
    .search_o   (search),
    .found_o    (found),
    .mfrac_o    (mfrac)
  );

  // Pack the result beat
  assign m_axis_tdata = {4'd0, mfrac, found, search, pinned, sats, half, center};

endmodule

// ===== hdl/dsa_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsa_checker
// Port-level checks of the Doppler search aiding block, bound to the top.
// ----------------------------------------------------------------------------
module dsa_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic [dsa_pkg::InDataW-1:0]   s_axis_tdata,
  input logic [dsa_pkg::ModeW-1:0]     s_axis_tuser,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [dsa_pkg::OutDataW-1:0]  m_axis_tdata,
  input logic                          psel,
  input logic                          penable,
  input logic                          pwrite,
  input logic [dsa_pkg::CfgAddrW-1:0]  paddr,
  input logic [dsa_pkg::CfgDataW-1:0]  pwdata,
  input logic [dsa_pkg::CfgDataW-1:0]  prdata,
  input logic                          pready
);

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // A working mode keeps the input closed for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready &&
    (s_axis_tuser <= dsa_pkg::MODE_EST_SAT) |=> !s_axis_tready)
    else $error("input taken while an item is in progress");

  // A measured satellite is always searchable
  a_found_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[59] |-> m_axis_tdata[58])
    else $error("measured satellite flagged not searchable");

endmodule

bind doppler_search_aiding_top dsa_checker u_dsa_checker (.*);

// ===== verif/doppler_search_aiding_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// doppler_search_aiding_top_tb
// Self-checking bench for the Doppler search aiding block. A scoreboard
// class mirrors the sum, count, per-satellite tables and registers, and
// predicts each estimate beat; random gaps and a long receiver hold-off
// shake the stream handshakes across several register settings.
// ----------------------------------------------------------------------------
module doppler_search_aiding_top_tb;
  import dsa_pkg::*;

  localparam int WatchdogLimit = 4000;
  localparam int DrainWait     = 150;

  typedef struct {
    logic [ModeW-1:0] mode;
    logic [ConsW-1:0] cons;
    logic [PrnW-1:0]  prn;
    logic [DopW-1:0]  dop;
    logic [CarW-1:0]  car;
    logic             above;
    logic [FracW-1:0] los;
  } aid_item_t;

  // --------------------------------------------------------------------------
  // Scoreboard: search window predictor and queue of pending windows
  // --------------------------------------------------------------------------
  class search_window_sb;
    logic [BandW-1:0]  band_wide, band_narrow, band_vnar, band_alm;
    logic signed [63:0] clk_frac;
    logic              clk_valid;
    logic signed [63:0] frac_sum;
    int unsigned       rep_cnt;
    logic signed [63:0] meas_frac [512];
    bit                meas_ok [512];
    logic [40:0]       pred_entry [512];
    bit                pred_ok [512];
    logic [OutDataW-1:0] windows_q[$];
    int                errors;

    function new();
      band_wide = 5000; band_narrow = 1000; band_vnar = 250; band_alm = 250;
      clk_frac = 0; clk_valid = 0; frac_sum = 0; rep_cnt = 0; errors = 0;
      foreach (meas_ok[i]) begin
        meas_ok[i] = 0;
        pred_ok[i] = 0;
      end
    endfunction

    function void set_reg(reg_e idx, logic [63:0] val);
      case (idx)
        REG_BAND_WIDE:   band_wide = val[15:0];
        REG_BAND_NARROW: band_narrow = val[15:0];
        REG_BAND_VNAR:   band_vnar = val[15:0];
        REG_BAND_ALM:    band_alm = val[15:0];
        REG_CLK_FRAC:    clk_frac = {{24{val[39]}}, val[39:0]};
        REG_CLK_VALID:   clk_valid = val[0];
        default: ;
      endcase
    endfunction

    // Doppler over carrier, scaled, rounded half away, saturated to 40 bits
    function logic signed [63:0] dop_to_frac(logic [DopW-1:0] dop, logic [CarW-1:0] car);
      logic signed [63:0] d;
      logic [127:0] mag, q, r, lim;
      logic neg;
      d = {{39{dop[24]}}, dop};
      neg = d < 0;
      mag = neg ? 128'(-d) : 128'(d);
      lim = neg ? (128'd1 << 39) : (128'd1 << 39) - 1;
      if (car == 0) begin
        q = (mag != 0) ? lim : 0;
      end else begin
        q = (mag << ScaleShift) / car;
        r = (mag << ScaleShift) % car;
        if (q <= lim && 2 * r >= car) q = q + 1;
        if (q > lim) q = lim;
      end
      return neg ? -$signed(q[63:0]) : $signed(q[63:0]);
    endfunction

    // Fraction times carrier back to 1/16 Hz, saturated to 25 bits
    function logic [CenterW-1:0] frac_to_center(logic signed [63:0] f, logic [CarW-1:0] car);
      logic [127:0] mag, res, lim;
      logic neg;
      neg = f < 0;
      mag = neg ? 128'(-f) : 128'(f);
      lim = neg ? (128'd1 << 24) : (128'd1 << 24) - 1;
      res = (mag * car + (128'd1 << (ScaleShift - 1))) >> ScaleShift;
      if (res > lim) res = lim;
      return neg ? CenterW'(-res) : CenterW'(res);
    endfunction

    // Mean fraction, halved while only one report has been counted
    function logic signed [63:0] mean_frac();
      logic [63:0] mag, m;
      logic neg;
      if (rep_cnt == 0) return 0;
      neg = frac_sum < 0;
      mag = neg ? -frac_sum : frac_sum;
      m = (mag + rep_cnt / 2) / rep_cnt;
      if (rep_cnt == 1) m = (m + 1) >> 1;
      return neg ? -$signed(m) : $signed(m);
    endfunction

    function void note_item(aid_item_t it);
      int slot;
      logic signed [63:0] s, f, mf;
      logic [BandW-1:0] half;
      logic pinned, search, found;
      slot = {it.cons, it.prn};
      f = 0; mf = 0; half = band_wide; pinned = 0; search = 1; found = 0;
      case (it.mode)
        MODE_REP_COM: begin
          s = frac_sum + dop_to_frac(it.dop, it.car);
          if (s > (64'sd1 <<< 55) - 1) s = (64'sd1 <<< 55) - 1;
          if (s < -(64'sd1 <<< 55)) s = -(64'sd1 <<< 55);
          frac_sum = s;
          if (rep_cnt < 65535) rep_cnt++;
        end
        MODE_REP_SAT: begin
          meas_frac[slot] = dop_to_frac(it.dop, it.car);
          meas_ok[slot] = 1;
        end
        MODE_SET_PRED: begin
          pred_entry[slot] = {it.above, it.los};
          pred_ok[slot] = 1;
        end
        MODE_EST_COM, MODE_EST_SAT: begin
          if (it.mode == MODE_EST_SAT && meas_ok[slot]) begin
            found = 1; mf = meas_frac[slot]; f = mf;
            half = band_alm; pinned = clk_valid;
          end else if (it.mode == MODE_EST_SAT && pred_ok[slot]) begin
            f = $signed({{24{pred_entry[slot][39]}}, pred_entry[slot][39:0]})
                + (clk_valid ? clk_frac : mean_frac());
            half = band_alm; pinned = clk_valid; search = pred_entry[slot][40];
          end else if (clk_valid) begin
            f = clk_frac; half = band_vnar; pinned = 1;
          end else if (rep_cnt != 0) begin
            f = mean_frac();
            half = rep_cnt >= 2 ? band_narrow : band_wide;
          end
          windows_q.push_back({4'd0, mf[FracW-1:0], found, search, pinned,
                               16'(rep_cnt), half, frac_to_center(f, it.car)});
        end
        default: ;  // unused modes are dropped
      endcase
    endfunction

    function void cmp(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
        errors++;
        if (errors <= 10)
          $display("%0t: %s mismatch: expected %h, got %h", $realtime, name, exp_v, act_v);
      end
    endfunction

    function void check_window(logic [OutDataW-1:0] act);
      logic [OutDataW-1:0] e;
      if (windows_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("%0t: unexpected result beat %h", $realtime, act);
        return;
      end
      e = windows_q.pop_front();
      cmp("center", e[24:0], act[24:0]);
      cmp("half_width_hz", e[40:25], act[40:25]);
      cmp("sats_used", e[56:41], act[56:41]);
      cmp("clock_pinned", e[57], act[57]);
      cmp("searchable", e[58], act[58]);
      cmp("measured_found", e[59], act[59]);
      cmp("measured_fraction", e[99:60], act[99:60]);
    endfunction
  endclass

  logic                clk_i = 0;
  logic                rst_ni = 0;
  logic                s_axis_tvalid = 0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;   // cons, prn, doppler, carrier, above, los
  logic [ModeW-1:0]    s_axis_tuser = '0;   // mode
  logic                m_axis_tvalid;
  logic                m_axis_tready = 0;
  logic [OutDataW-1:0] m_axis_tdata;        // center, half, sats, pinned, search, found, mfrac
  logic                psel = 0, penable = 0, pwrite = 0;
  logic [CfgAddrW-1:0] paddr = '0;
  logic [CfgDataW-1:0] pwdata = '0;
  logic [CfgDataW-1:0] prdata;
  logic                pready;

  search_window_sb sb = new();
  bit   calm = 0;       // no idling on either side
  bit   long_hold = 0;  // receiver stalls for a long stretch
  int   idle_cycles = 0;

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  doppler_search_aiding_top dut (.*);

  // Watchdog on cycles without any accepted beat or APB access
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
      idle_cycles <= 0;
    else if (idle_cycles >= WatchdogLimit) begin
      $display("Simulation FAILED");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      gap = calm ? 0 : $urandom_range(0, 3);
      if (long_hold) begin
        gap = 400;
        long_hold = 0;
      end
      if (gap > 0) begin
        m_axis_tready <= 0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      sb.check_window(m_axis_tdata);
    end
  end

  task automatic send_item(aid_item_t it);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser  <= it.mode;
    s_axis_tdata  <= {6'd0, it.los, it.above, it.car, it.dop, it.prn, it.cons};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_item(it);
  endtask

  task automatic reg_write(reg_e idx, logic [63:0] val);
    psel <= 1; pwrite <= 1; penable <= 0;
    paddr <= CfgAddrW'(idx * 8); pwdata <= val;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    sb.set_reg(idx, val);
  endtask

  // Drop valid right after the last beat and wait until every window is out
  task automatic drain();
    s_axis_tvalid <= 0;
    while (sb.windows_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic load_regs(logic [15:0] w, logic [15:0] n, logic [15:0] v,
                           logic [15:0] a, logic [39:0] cf, logic cv);
    reg_write(REG_BAND_WIDE, 64'(w));
    reg_write(REG_BAND_NARROW, 64'(n));
    reg_write(REG_BAND_VNAR, 64'(v));
    reg_write(REG_BAND_ALM, 64'(a));
    reg_write(REG_CLK_FRAC, 64'(cf));
    reg_write(REG_CLK_VALID, 64'(cv));
  endtask

  function automatic logic [39:0] rand40();
    return {8'($urandom), 32'($urandom)};
  endfunction

  function automatic aid_item_t mk(logic [2:0] mode, logic [2:0] cons, logic [5:0] prn,
                                   logic [24:0] dop, logic [30:0] car,
                                   logic above, logic [39:0] los);
    aid_item_t it;
    it.mode = mode; it.cons = cons; it.prn = prn; it.dop = dop;
    it.car = car; it.above = above; it.los = los;
    return it;
  endfunction

  // Mostly realistic traffic on a small pool of satellites, some raw noise
  function automatic aid_item_t rand_item();
    aid_item_t it;
    int k;
    k = $urandom_range(0, 99);
    it.mode  = 3'($urandom_range(0, 4));
    it.cons  = 3'($urandom_range(0, 7));
    it.prn   = 6'($urandom_range(0, 3) * 21);
    it.dop   = 25'($signed($urandom_range(0, 160000)) - 80000);
    it.car   = 31'($urandom_range(1100000000, 1700000000));
    it.above = 1'($urandom);
    it.los   = 40'($signed($urandom_range(0, 32'h7fffffff)) - 32'sh3fffffff) <<< 4;
    if (k < 15) begin
      it.prn  = 6'($urandom);
      it.dop  = 25'($urandom);
      it.car  = 31'($urandom);
      it.los  = rand40();
      if (k < 2) it.mode = 3'($urandom_range(5, 7));
    end else if (k < 20) begin
      it.car = 31'($urandom_range(0, 40));
    end
    return it;
  endfunction

  initial begin
    aid_item_t dir[$];
    repeat (11) @(posedge clk_i);
    rst_ni <= 1;

    // Directed: empty state, zero carrier, saturation, single report halving
    dir.push_back(mk(MODE_EST_COM, 0, 0, 0, 1575420000, 0, 0));
    dir.push_back(mk(MODE_EST_SAT, 7, 63, 0, 0, 0, 0));
    dir.push_back(mk(MODE_REP_COM, 1, 1, 25'h0ffffff, 1, 0, 0));
    dir.push_back(mk(MODE_EST_COM, 0, 0, 0, 31'h7fffffff, 0, 0));
    dir.push_back(mk(MODE_REP_COM, 1, 1, 25'h1000000, 1, 0, 0));
    dir.push_back(mk(MODE_EST_COM, 0, 0, 0, 1575420000, 0, 0));
    dir.push_back(mk(MODE_REP_COM, 1, 1, 25'd48000, 0, 0, 0));
    dir.push_back(mk(MODE_REP_COM, 1, 1, 25'h1fff000, 0, 0, 0));
    dir.push_back(mk(MODE_REP_COM, 1, 1, 0, 0, 0, 0));
    dir.push_back(mk(MODE_EST_COM, 0, 0, 0, 1575420000, 0, 0));
    dir.push_back(mk(MODE_REP_SAT, 2, 5, 25'd32000, 1575420000, 0, 0));
    dir.push_back(mk(MODE_EST_SAT, 2, 5, 0, 1575420000, 0, 0));
    dir.push_back(mk(MODE_REP_SAT, 7, 63, 25'h1000000, 0, 0, 0));
    dir.push_back(mk(MODE_EST_SAT, 7, 63, 0, 0, 0, 0));
    dir.push_back(mk(MODE_SET_PRED, 3, 9, 0, 1, 0, 40'h7fffffffff));
    dir.push_back(mk(MODE_EST_SAT, 3, 9, 0, 31'h7fffffff, 0, 0));
    dir.push_back(mk(MODE_SET_PRED, 4, 0, 0, 1, 1, 40'h8000000000));
    dir.push_back(mk(MODE_EST_SAT, 4, 0, 0, 1207140000, 0, 0));
    dir.push_back(mk(3'd5, 0, 0, 0, 0, 0, 0));
    dir.push_back(mk(3'd6, 0, 0, 0, 0, 0, 0));
    dir.push_back(mk(3'd7, 7, 63, 25'h1ffffff, 31'h7fffffff, 1, 40'hffffffffff));
    foreach (dir[i]) send_item(dir[i]);
    drain();

    // Random phases over several register settings
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        1: load_regs(0, 0, 0, 0, 40'h7fffffffff, 1);
        2: load_regs(16'hffff, 16'hffff, 16'hffff, 16'hffff, 40'h8000000000, 1);
        3: load_regs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                     rand40(), 0);
        4: load_regs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                     40'($signed($urandom_range(0, 2000000)) - 1000000) <<< 12, 1);
        default: ;
      endcase
      for (int n = 0; n < 96; n++) begin
        calm = (n >= 70 && n < 85);
        if (ph == 2 && n == 10) long_hold = 1;
        send_item(rand_item());
      end
      calm = 0;
      drain();
    end

    if (sb.errors == 0 && sb.windows_q.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/dsa_pkg.sv
hdl/dsa_ram.sv
hdl/dsa_ctrl.sv
hdl/dsa_dp.sv
hdl/doppler_search_aiding_top.sv
hdl/dsa_checker.sv
verif/doppler_search_aiding_top_tb.sv
